FILE: rtl/token_splitter_defines.svh
// assertion macros used by the token splitter queue
`ifndef TOKEN_SPLITTER_DEFINES_SVH
`define TOKEN_SPLITTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TSP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tsp_pkg.sv
package tsp_pkg;

	// character constants
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// one output item
	typedef struct packed {
		logic [7:0] out_char;
		logic       token_end;
	} tok_t;

	// what the front hands the queue in one cycle: zero, one or two items
	typedef struct packed {
		logic [1:0] num;
		tok_t       first;
		tok_t       second;
	} push_t;

	function automatic logic is_word(input logic [7:0] c);
		is_word = (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
			(c >= CH_UA && c <= CH_UZ);
	endfunction

endpackage

FILE: rtl/tsp_if.sv
interface tsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source(output valid, output in_char, output end_of_input, input ready);
	modport sink(input valid, input in_char, input end_of_input, output ready);
endinterface

interface tsp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       token_end;

	modport source(output valid, output out_char, output token_end, input ready);
	modport sink(input valid, input out_char, input token_end, output ready);
endinterface

FILE: rtl/token_splitter.sv
// an accepted item's resolved tokens enter the queue at acceptance and leave from its head
// throughput: one input item per cycle unless stalled; it yields zero, one or two output items
// the queue drains one item per ready cycle; input stalls while fewer than two slots are free
// reset: arst_n clears the held byte and kind and empties the queue at once
module token_splitter
	import tsp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	tsp_in_if.sink    text,
	tsp_out_if.source tokens
);

	push_t push;
	logic  room;

	// classify and resolve held byte
	tsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.room   (room),
		.push   (push)
	);

	// item queue and output side
	tsp_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tokens (tokens)
	);

endmodule

FILE: rtl/tsp_front.sv
module tsp_front
	import tsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	tsp_in_if.sink   text,
	input  logic     room,
	output push_t    push
);

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_WORD = 2'd1;
	localparam logic [1:0] KIND_DASH = 2'd2;
	localparam logic [1:0] KIND_LT   = 2'd3;

	logic [7:0] held_byte_q, held_byte_d;
	logic [1:0] held_kind_q, held_kind_d;
	logic       accept;
	logic       r0_vld, r1_vld;
	tok_t       r0, r1;
	logic       fresh;
	logic [7:0] c;

	assign text.ready = room;
	assign accept     = text.valid && text.ready;
	assign c          = text.in_char;

	// resolve held byte against the incoming one, then classify fresh byte
	always_comb begin
		r0_vld      = 1'b0;
		r1_vld      = 1'b0;
		r0          = '{out_char: held_byte_q, token_end: 1'b1};
		r1          = '{out_char: c, token_end: 1'b1};
		fresh       = 1'b0;
		held_byte_d = held_byte_q;
		held_kind_d = held_kind_q;
		if (text.end_of_input) begin
			r0_vld      = (held_kind_q != KIND_NONE);
			held_byte_d = '0;
			held_kind_d = KIND_NONE;
		end else begin
			case (held_kind_q)
				KIND_WORD: begin
					r0_vld = 1'b1;
					if (is_word(c)) begin
						r0.token_end = 1'b0;
						held_byte_d  = c;
					end else begin
						fresh = 1'b1;
					end
				end
				KIND_DASH, KIND_LT: begin
					r0_vld = 1'b1;
					if ((held_kind_q == KIND_DASH && c == CH_GT) ||
						(held_kind_q == KIND_LT && c == CH_LT)) begin
						r0.token_end = 1'b0;
						r1_vld       = 1'b1;
						held_byte_d  = '0;
						held_kind_d  = KIND_NONE;
					end else begin
						fresh = 1'b1;
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase
			if (fresh) begin
				held_byte_d = c;
				if (is_word(c)) begin
					held_kind_d = KIND_WORD;
				end else if (c == CH_DASH) begin
					held_kind_d = KIND_DASH;
				end else if (c == CH_LT) begin
					held_kind_d = KIND_LT;
				end else begin
					held_byte_d = '0;
					held_kind_d = KIND_NONE;
					r1_vld      = (c != CH_SPACE) && (c != CH_NL);
				end
			end
		end
	end

	// pack items so the first slot is always used first
	always_comb begin
		push.num    = 2'd0;
		push.first  = r0;
		push.second = r1;
		if (accept) begin
			push.num = {1'b0, r0_vld} + {1'b0, r1_vld};
			if (!r0_vld) begin
				push.first = r1;
			end
		end
	end

	// held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q <= '0;
			held_kind_q <= KIND_NONE;
		end else if (accept) begin
			held_byte_q <= held_byte_d;
			held_kind_q <= held_kind_d;
		end
	end

endmodule

FILE: rtl/tsp_queue.sv
`include "token_splitter_defines.svh"

module tsp_queue
	import tsp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      room,
	tsp_out_if.source tokens
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	tok_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW-1:0] wr_nxt1, wr_nxt2;
	logic [CW-1:0] count_q;
	logic          pop;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		inc = (p == LAST) ? '0 : p + 1'b1;
	endfunction

	assign wr_nxt1 = inc(wr_ptr_q);
	assign wr_nxt2 = inc(wr_nxt1);

	// accept from the front only while at least two slots are free
	assign room = (count_q <= CW'(DEPTH - 2));

	assign tokens.valid     = (count_q != '0);
	assign tokens.out_char  = mem_q[rd_ptr_q].out_char;
	assign tokens.token_end = mem_q[rd_ptr_q].token_end;
	assign pop              = tokens.valid && tokens.ready;

	// item storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_nxt1] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.num)
				2'd1:    wr_ptr_q <= wr_nxt1;
				2'd2:    wr_ptr_q <= wr_nxt2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.num) - CW'(pop);
		end
	end

	`TSP_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count overflow")
	`TSP_ASSERT_SAME(a_push_room, push.num != 2'd0, room, "push without room")
	`TSP_ASSERT_NEXT(a_stall_head, tokens.valid && !tokens.ready,
		tokens.valid && $stable(rd_ptr_q), "head moved while stalled")

endmodule

FILE: tb/token_splitter_test.sv
module token_splitter_test;
	import tsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;

	// what the splitter is holding back while it waits to see the next byte
	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_WORD = 2'd1,
		HOLD_DASH = 2'd2,
		HOLD_LT   = 2'd3
	} hold_kind_e;

	logic clk = 1'b0;
	logic arst_n;

	tsp_in_if  text_if();
	tsp_out_if tokens_if();

	token_splitter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.tokens (tokens_if)
	);

	// predicted token stream and the predictor's copy of the held byte
	tok_t       expected_tokens[$];
	logic [7:0] hold_byte = '0;
	hold_kind_e hold_kind = HOLD_NONE;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent    = 0;
	int fail_count    = 0;
	int idle_cycles   = 0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_alnum(input logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
			(c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic void expect_token(input logic [7:0] c, input logic last);
		tok_t t;
		t.out_char  = c;
		t.token_end = last;
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	// tokens caused by one accepted item
	function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
		if (eoi) begin
			if (hold_kind != HOLD_NONE)
				expect_token(hold_byte, 1'b1);
			hold_byte = '0;
			hold_kind = HOLD_NONE;
			return;
		end
		// settle the held byte against the new one
		case (hold_kind)
			HOLD_WORD: begin
				if (is_alnum(c)) begin
					expect_token(hold_byte, 1'b0);
					hold_byte = c;
					return;
				end
				expect_token(hold_byte, 1'b1);
			end
			HOLD_DASH: begin
				if (c == CH_GT) begin
					expect_token(hold_byte, 1'b0);
					expect_token(c, 1'b1);
					hold_byte = '0;
					hold_kind = HOLD_NONE;
					return;
				end
				expect_token(hold_byte, 1'b1);
			end
			HOLD_LT: begin
				if (c == CH_LT) begin
					expect_token(hold_byte, 1'b0);
					expect_token(c, 1'b1);
					hold_byte = '0;
					hold_kind = HOLD_NONE;
					return;
				end
				expect_token(hold_byte, 1'b1);
			end
			default: ;
		endcase
		hold_byte = '0;
		hold_kind = HOLD_NONE;
		// new byte starts fresh
		if (is_alnum(c)) begin
			hold_byte = c;
			hold_kind = HOLD_WORD;
		end else if (c == CH_DASH) begin
			hold_byte = c;
			hold_kind = HOLD_DASH;
		end else if (c == CH_LT) begin
			hold_byte = c;
			hold_kind = HOLD_LT;
		end else if (c != CH_SPACE && c != CH_NL) begin
			expect_token(c, 1'b1);
		end
	endfunction

	// one item on the text channel, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid        <= 1'b1;
		text_if.in_char      <= c;
		text_if.end_of_input <= eoi;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		predict_tokens(c, eoi);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_alnum();
		case ($urandom_range(2))
			0: return 8'(CH_0 + $urandom_range(9));
			1: return 8'(CH_LA + $urandom_range(25));
			default: return 8'(CH_UA + $urandom_range(25));
		endcase
	endfunction

	// class boundaries: bytes just outside and at each end of digits and letters
	task automatic test_char_classes();
		send_text("/09:@AZ[`az{");
	endtask

	// operators, a word ended by an operator, lone dash and less-than, flush of a word
	task automatic test_operators();
		send_text("w->w<<-<-x");
		send_item(8'h00, 1'b1);
	endtask

	// byte extremes, separators, end of input with nothing held
	task automatic test_byte_extremes();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(CH_NL, 1'b0);
		send_item(8'hFF, 1'b1);
	endtask

	// mostly well-formed text: words, operators, separators, with noise and flushes
	task automatic test_random_text(input int count);
		int target;
		int pick;
		int len;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				len = $urandom_range(1, 8);
				repeat (len) send_item(random_alnum(), 1'b0);
			end else if (pick < 50) begin
				send_item(CH_DASH, 1'b0);
				send_item(CH_GT, 1'b0);
			end else if (pick < 60) begin
				send_item(CH_LT, 1'b0);
				send_item(CH_LT, 1'b0);
			end else if (pick < 68) begin
				send_item($urandom_range(1) ? CH_DASH : CH_LT, 1'b0);
				send_item(8'($urandom()), 1'b0);
			end else if (pick < 80) begin
				send_item($urandom_range(1) ? CH_SPACE : CH_NL, 1'b0);
			end else if (pick < 85) begin
				send_item(CH_GT, 1'b0);
			end else if (pick < 95) begin
				send_item(8'($urandom()), 1'b0);
			end else begin
				send_item(8'($urandom()), 1'b1);
			end
		end
	endtask

	// wait for the token stream to drain, then report
	task automatic finish_run();
		text_if.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("token_splitter test passed");
		else
			$display("token_splitter test failed");
		$finish;
	endtask

	// receiver stalls and token check
	always @(posedge clk) begin
		tok_t want;
		if (tokens_if.valid && tokens_if.ready) begin
			if (expected_tokens.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t unexpected token byte %h end %b", $realtime,
						tokens_if.out_char, tokens_if.token_end);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (tokens_if.out_char !== want.out_char ||
						tokens_if.token_end !== want.token_end) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t mismatch: expected byte %h end %b, got byte %h end %b",
							$realtime, want.out_char, want.token_end,
							tokens_if.out_char, tokens_if.token_end);
					fail_count++;
				end
			end
		end
		tokens_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((text_if.valid && text_if.ready) || (tokens_if.valid && tokens_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("token_splitter test failed");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n               = 1'b0;
		text_if.valid        = 1'b0;
		text_if.in_char      = '0;
		text_if.end_of_input = 1'b0;
		tokens_if.ready      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 35;
		recv_idle_pct = 49;
		test_char_classes();
		test_operators();
		test_byte_extremes();
		test_random_text(360);

		send_idle_pct = 49;
		recv_idle_pct = 35;
		test_random_text(360);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(360);

		finish_run();
	end

endmodule

FILE: token_splitter.f
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_if.sv
rtl/tsp_front.sv
rtl/tsp_queue.sv
rtl/token_splitter.sv
tb/token_splitter_test.sv
